// ----- design/assert_macros.svh -----
// assertion macros used by the top-level design file
// no dependencies; define NO_ASSERTIONS to drop every check
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPLIES(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst, pre, post, msg)

`define ASSERT_NEXT(label, clk, rst, pre, post, msg)

`endif

`endif

// ----- design/dmd_pkg.sv -----
// types and constants of the dual motor drive with encoder tachometer
// no dependencies
package dmd_pkg;

   localparam logic [1:0] KIND_SET_SPEED  = 2'd0;
   localparam logic [1:0] KIND_RIGHT_ENC  = 2'd1;
   localparam logic [1:0] KIND_LEFT_ENC   = 2'd2;
   localparam logic [1:0] KIND_TICK       = 2'd3;

   localparam logic signed [15:0] SPEED_LIMIT  = 16'sd255;
   localparam logic [7:0]         PERIOD_RESET = 8'd7;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [15:0] right_speed;
      logic signed [15:0] left_speed;
   } dmd_req_type;

   typedef struct packed {
      logic [7:0]         right_duty;
      logic [7:0]         left_duty;
      logic               right_forward;
      logic               left_forward;
      logic               report_valid;
      logic signed [15:0] right_report;
      logic signed [15:0] left_report;
   } dmd_rsp_type;

   typedef struct packed {
      logic [7:0] duty;
      logic       forward;
      logic       stopped;
   } dmd_speed_type;

endpackage

// ----- design/dual_motor_drive_encoder_tach.sv -----
// top level of the dual motor drive with encoder tachometer
// depends on dmd_pkg and assert_macros.svh
//
// A request is applied to the channel state at the edge where it is
// accepted; its response sits in the output register the next cycle. A
// new request is taken every cycle while the response side keeps up; a
// response left waiting in the output register holds off the next request
// until the response side takes it. A set-speed request clamps both speeds
// to -255..255 and updates duty and direction, an encoder request counts
// its channel, and a tick advances the prescaler, reporting and clearing
// both counts once every report_period+1 ticks. The report period must be
// written through the csr port while it is idle; the block does not enforce it.
`include "assert_macros.svh"

module dual_motor_drive_encoder_tach
   import dmd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dmd_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output dmd_rsp_type rsp_data,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data
);

   logic [7:0]  period_ff;
   logic [15:0] right_count_ff, right_count_in;
   logic [15:0] left_count_ff, left_count_in;
   logic        right_dir_ff, right_dir_in;
   logic        left_dir_ff, left_dir_in;
   logic        right_stopped_ff, right_stopped_in;
   logic        left_stopped_ff, left_stopped_in;
   logic [7:0]  prescale_ff, prescale_in;
   logic [7:0]  right_duty_ff, right_duty_in;
   logic [7:0]  left_duty_ff, left_duty_in;
   logic        rsp_valid_ff, rsp_valid_in;
   dmd_rsp_type rsp_ff, rsp_in;
   logic        req_accept;
   logic        report;
   dmd_speed_type right_split, left_split;

   function automatic dmd_speed_type split_speed(input logic signed [15:0] s);
      dmd_speed_type r;
      logic signed [15:0] neg;
      neg = -s;
      if (s > SPEED_LIMIT) begin
         r.duty    = 8'hff;
         r.forward = 1'b1;
      end else if (s < -SPEED_LIMIT) begin
         r.duty    = 8'hff;
         r.forward = 1'b0;
      end else if (s > 16'sd0) begin
         r.duty    = s[7:0];
         r.forward = 1'b1;
      end else begin
         r.duty    = neg[7:0];
         r.forward = 1'b0;
      end
      r.stopped = (s == 16'sd0);
      return r;
   endfunction

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   assign right_split = split_speed(req_data.right_speed);
   assign left_split  = split_speed(req_data.left_speed);
   assign report      = (req_data.kind == KIND_TICK) && !(prescale_ff < period_ff);

   always_comb begin
      right_count_in   = right_count_ff;
      left_count_in    = left_count_ff;
      right_dir_in     = right_dir_ff;
      left_dir_in      = left_dir_ff;
      right_stopped_in = right_stopped_ff;
      left_stopped_in  = left_stopped_ff;
      prescale_in      = prescale_ff;
      right_duty_in    = right_duty_ff;
      left_duty_in     = left_duty_ff;
      case (req_data.kind)
         KIND_SET_SPEED: begin
            right_duty_in    = right_split.duty;
            right_dir_in     = right_split.forward;
            right_stopped_in = right_split.stopped;
            left_duty_in     = left_split.duty;
            left_dir_in      = left_split.forward;
            left_stopped_in  = left_split.stopped;
         end
         KIND_RIGHT_ENC: begin
            if (right_dir_ff) begin
               right_count_in = 16'(right_count_ff + 16'd1);
            end else if (!right_stopped_ff) begin
               right_count_in = 16'(right_count_ff - 16'd1);
            end
         end
         KIND_LEFT_ENC: begin
            if (left_dir_ff) begin
               left_count_in = 16'(left_count_ff + 16'd1);
            end else if (!left_stopped_ff) begin
               left_count_in = 16'(left_count_ff - 16'd1);
            end
         end
         default: begin
            if (report) begin
               prescale_in    = 8'd0;
               right_count_in = 16'd0;
               left_count_in  = 16'd0;
            end else begin
               prescale_in = 8'(prescale_ff + 8'd1);
            end
         end
      endcase

      rsp_in.right_duty    = right_duty_in;
      rsp_in.left_duty     = left_duty_in;
      rsp_in.right_forward = right_dir_in;
      rsp_in.left_forward  = left_dir_in;
      rsp_in.report_valid  = report;
      rsp_in.right_report  = report ? right_count_ff : 16'sd0;
      rsp_in.left_report   = report ? left_count_ff : 16'sd0;

      rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff        <= PERIOD_RESET;
         right_count_ff   <= 16'd0;
         left_count_ff    <= 16'd0;
         right_dir_ff     <= 1'b1;
         left_dir_ff      <= 1'b1;
         right_stopped_ff <= 1'b1;
         left_stopped_ff  <= 1'b1;
         prescale_ff      <= 8'd0;
         right_duty_ff    <= 8'd0;
         left_duty_ff     <= 8'd0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            period_ff <= csr_write_data;
         end
         if (req_accept) begin
            right_count_ff   <= right_count_in;
            left_count_ff    <= left_count_in;
            right_dir_ff     <= right_dir_in;
            left_dir_ff      <= left_dir_in;
            right_stopped_ff <= right_stopped_in;
            left_stopped_ff  <= left_stopped_in;
            prescale_ff      <= prescale_in;
            right_duty_ff    <= right_duty_in;
            left_duty_ff     <= left_duty_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= rsp_in;
      end
   end

   `ASSERT_NEXT(a_accept_gives_rsp, clock, reset, req_accept, rsp_valid_ff,
      "request accepted but no response")
   `ASSERT_NEXT(a_report_clears, clock, reset, req_accept && report,
      (right_count_ff == 16'd0) && (left_count_ff == 16'd0) && (prescale_ff == 8'd0),
      "counts not cleared after report")
   `ASSERT_IMPLIES(a_right_stop_duty, clock, reset, right_stopped_ff,
      right_duty_ff == 8'd0, "right stopped with nonzero duty")
   `ASSERT_IMPLIES(a_left_stop_duty, clock, reset, left_stopped_ff,
      left_duty_ff == 8'd0, "left stopped with nonzero duty")
   `ASSERT_IMPLIES(a_report_zero, clock, reset, rsp_valid_ff && !rsp_ff.report_valid,
      (rsp_ff.right_report == 16'sd0) && (rsp_ff.left_report == 16'sd0),
      "report data without report")

endmodule
